// File: rtl/indexed_list_engine_assert.svh
// Assertion helpers for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ILE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ile assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ILE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ile assertion failed");

`endif

// File: rtl/ile_pkg.sv
`default_nettype none
package ile_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // request kinds
  localparam logic [KIND_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] REQ_EDIT   = 3'd2;
  localparam logic [KIND_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] REQ_READ   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECODE,
    SEQ_SH_RD,
    SEQ_SH_WR,
    SEQ_PUT,
    SEQ_RD_REQ,
    SEQ_RD_WAIT,
    SEQ_FIN
  } seq_state_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     item_count;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/ile_if.sv
`default_nettype none
interface ile_req_if import ile_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_OUT_W-1:0]     item_count;

  modport source (output valid, output status, output read_value, output item_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input item_count,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/ile_ram.sv
`default_nettype none
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ile_seq.sv
`default_nettype none
module ile_seq import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request side
  input  wire logic                     req_take,
  input  wire logic [KIND_W-1:0]        req_type,
  input  wire logic [POS_W-1:0]         req_pos,
  input  wire logic signed [DATA_W-1:0] req_value,
  output logic                          idle,
  // entry store
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [DATA_W-1:0]             ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  wire logic [DATA_W-1:0]        ram_rdata,
  // result side
  output logic                          res_valid,
  output res_t                          res,
  input  wire logic                     res_take
);

  // compare width covers both the position field and the count
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  seq_state_t state_r, state_nxt;

  logic [KIND_W-1:0] kind_r,   kind_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [DATA_W-1:0] val_r,    val_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [AW-1:0]     idx_r,    idx_nxt;
  logic [AW-1:0]     tgt_r,    tgt_nxt;
  logic [DATA_W-1:0] rd_val_r, rd_val_nxt;
  logic [CW-1:0]     count_r,  count_nxt;

  logic [CMPW-1:0] pos_ext, cnt_ext, idx_ext, tgt_ext;
  logic            full, up;
  logic [AW-1:0]   idx_dec, idx_inc;
  logic            up_more, dn_more;

  // index unit: decrement and increment steps, up and down compares
  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count_r);
  assign idx_ext = CMPW'(idx_r);
  assign tgt_ext = CMPW'(tgt_r);
  assign full    = (count_r == CW'(DEPTH));
  assign up      = (kind_r inside {REQ_PUSH, REQ_INSERT});
  assign idx_dec = idx_r - AW'(1);
  assign idx_inc = idx_r + AW'(1);
  assign up_more = ((idx_ext - CMPW'(1)) > tgt_ext);
  assign dn_more = ((idx_ext + CMPW'(2)) < cnt_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (req_take) state_nxt = SEQ_DECODE;
      end
      SEQ_DECODE: begin
        state_nxt = SEQ_FIN;
        case (kind_r)
          REQ_PUSH: begin
            if (!full) state_nxt = (count_r != '0) ? SEQ_SH_RD : SEQ_PUT;
          end
          REQ_INSERT: begin
            if (pos_ext <= cnt_ext && !full) begin
              state_nxt = (cnt_ext > pos_ext) ? SEQ_SH_RD : SEQ_PUT;
            end
          end
          REQ_EDIT: begin
            if (pos_ext < cnt_ext) state_nxt = SEQ_PUT;
          end
          REQ_DELETE: begin
            if (pos_ext + CMPW'(1) < cnt_ext) state_nxt = SEQ_SH_RD;
          end
          REQ_READ: begin
            if (pos_ext < cnt_ext) state_nxt = SEQ_RD_REQ;
          end
          default: state_nxt = SEQ_FIN;
        endcase
      end
      SEQ_SH_RD:   state_nxt = SEQ_SH_WR;
      SEQ_SH_WR: begin
        if (up) state_nxt = up_more ? SEQ_SH_RD : SEQ_PUT;
        else    state_nxt = dn_more ? SEQ_SH_RD : SEQ_FIN;
      end
      SEQ_PUT:     state_nxt = SEQ_FIN;
      SEQ_RD_REQ:  state_nxt = SEQ_RD_WAIT;
      SEQ_RD_WAIT: state_nxt = SEQ_FIN;
      SEQ_FIN: begin
        if (res_take) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle      = (state_r == SEQ_IDLE);
    res_valid = (state_r == SEQ_FIN);
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = AW'(pos_r);
    case (state_r)
      SEQ_SH_RD: begin
        ram_raddr = up ? idx_dec : idx_inc;
      end
      SEQ_SH_WR: begin
        ram_we = 1'b1;
      end
      SEQ_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = val_r;
      end
      default: ;
    endcase
    res.status     = status_r;
    res.read_value = rd_val_r;
    res.item_count = CNT_OUT_W'(count_nxt);
  end

  // datapath next values
  always_comb begin
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    tgt_nxt    = tgt_r;
    rd_val_nxt = rd_val_r;
    count_nxt  = count_r;
    case (state_r)
      SEQ_IDLE: begin
        if (req_take) begin
          kind_nxt = req_type;
          pos_nxt  = req_pos;
          val_nxt  = req_value;
        end
      end
      SEQ_DECODE: begin
        status_nxt = ST_OK;
        rd_val_nxt = '0;
        idx_nxt    = AW'(count_r);
        tgt_nxt    = AW'(pos_r);
        case (kind_r)
          REQ_PUSH: begin
            tgt_nxt = '0;
            if (full) status_nxt = ST_FULL;
          end
          REQ_INSERT: begin
            if (pos_ext > cnt_ext) status_nxt = ST_RANGE;
            else if (full)         status_nxt = ST_FULL;
          end
          REQ_EDIT, REQ_READ: begin
            if (pos_ext >= cnt_ext) status_nxt = ST_RANGE;
          end
          REQ_DELETE: begin
            idx_nxt = AW'(pos_r);
            if (pos_ext >= cnt_ext) status_nxt = ST_RANGE;
          end
          default: ;
        endcase
      end
      SEQ_SH_WR: begin
        idx_nxt = up ? idx_dec : idx_inc;
      end
      SEQ_RD_WAIT: begin
        rd_val_nxt = ram_rdata;
      end
      SEQ_FIN: begin
        // count moves once the result is handed over
        if (status_r == ST_OK) begin
          if (up)                        count_nxt = count_r + CW'(1);
          else if (kind_r == REQ_DELETE) count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_take) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    tgt_r    <= tgt_nxt;
    rd_val_r <= rd_val_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/indexed_list_engine.sv
// Steps from accept to registered result: decode, then an error or an unused code goes
//   straight to the result; edit writes once; read issues a read and waits for the data;
//   push/insert do a read/write pair per moved entry, then write the value; delete does a
//   pair per moved entry (moved entries: push count, insert count-position, delete count-position-1).
// Flow: one transaction at a time; the next is taken only after the result is registered.
// Reset: synchronous active-low rst_n clears count, sequencer and output valid; no store clear.
`default_nettype none
`include "indexed_list_engine_assert.svh"
module indexed_list_engine import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ile_req_if.sink   in_req,
  ile_rsp_if.source out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer <-> entry store
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic seq_idle;
  logic res_valid;
  logic res_take;
  res_t res;

  // output register: result waits here while a new transaction is taken
  logic out_valid_r;
  res_t out_res_r;

  logic req_take;

  // requests taken only while the sequencer is idle
  assign in_req.ready = seq_idle;
  assign req_take     = in_req.valid & seq_idle;

  // result moves into the output slot when it is empty or draining
  assign res_take = res_valid & (~out_valid_r | out_rsp.ready);

  ile_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_take  (req_take),
    .req_type  (in_req.req_type),
    .req_pos   (in_req.position),
    .req_value (in_req.value),
    .idle      (seq_idle),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // list entries, one read and one write port
  ile_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_res_r.status;
  assign out_rsp.read_value = out_res_r.read_value;
  assign out_rsp.item_count = out_res_r.item_count;

  // ---- checks ----
  // a taken transaction keeps the block busy the next cycle
  `ILE_ASSERT_NEXT(a_busy_after_take, in_req.valid && in_req.ready, !in_req.ready)
  // only an ok read carries a nonzero value
  `ILE_ASSERT_NOW(a_rd_only_ok, out_valid_r && (out_res_r.read_value != '0),
                  out_res_r.status == ST_OK)
  // a full report goes with a count at capacity
  `ILE_ASSERT_NOW(a_full_count, out_valid_r && (out_res_r.status == ST_FULL),
                  out_res_r.item_count == CNT_OUT_W'(DEPTH))

endmodule
`default_nettype wire
